FILE: hdl/lla_pkg.sv
// Shared types, constants and helpers for the linear layer block.
package lla_pkg;

   localparam int RES_W = 48;   // Q24.24 result width
   localparam int ACC_W = 40;   // prediction accumulator, holds 64 products plus bias

   typedef enum logic [2:0] {
      ACT_LOAD_W  = 3'd0,
      ACT_LOAD_B  = 3'd1,
      ACT_STORE_X = 3'd2,
      ACT_CLEAR_G = 3'd3,
      ACT_ERROR   = 3'd4,
      ACT_READ_WG = 3'd5,
      ACT_READ_BG = 3'd6,
      ACT_NONE    = 3'd7
   } act_type;

   localparam logic [1:0] KIND_PRED  = 2'd0;
   localparam logic [1:0] KIND_WGRAD = 2'd1;
   localparam logic [1:0] KIND_BGRAD = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_MAC,
      ST_DRAIN,
      ST_EMIT,
      ST_RD_A,
      ST_RD_B,
      ST_RD_C,
      ST_GCLR
   } state_type;

   typedef struct packed {
      logic cap;
      logic x_we;
      logic w_we;
      logic b_we;
      logic bg_sub;
      logic bg_clr;
      logic clr_w;
      logic clr_g;
      logic acc_init;
      logic mac_issue;
      logic rd_mul;
      logic out_pred;
      logic out_grad;
      logic out_last;
   } cmd_type;

   typedef struct packed {
      act_type act;
      logic    lastel;
      logic    s_ok;
      logic    r_ok;
      logic    c_ok;
      logic    pipe_busy;
      logic    out_free;
   } sts_type;

   function automatic logic signed [RES_W-1:0] sat48(input logic signed [RES_W:0] v);
      logic signed [RES_W-1:0] r;
      if (v[RES_W] != v[RES_W-1]) begin
         r = v[RES_W] ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
      end else begin
         r = v[RES_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: hdl/linear_layer_forward_and_gradient.sv
// Linear layer top: prediction x*W+b and L2-regularized gradient accumulation.
// Each load, each store without last_element and each unused action returns to idle after decode;
// an error element ends after its row walk and drain; a prediction does both, then gives one
// result per cycle while the response side accepts, for min(OUT_DIM,8) columns; gradient reads
// step through RD_A, RD_B and RD_C. Throughput is set by the row walk of the weight and input
// memories, one row a cycle. Clear gradients zeroes bias and weight gradients. After reset a
// clearing pass zeroes weights and weight gradients; req_tready stays low until it is done.
module linear_layer_forward_and_gradient import lla_pkg::*; #(
   parameter int IN_DIM  = 16,
   parameter int OUT_DIM = 8,
   parameter int BATCH   = 64
) (
   input  logic        clock,
   input  logic        reset,
   // configuration: lambda, unsigned Q4.12
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   // request transactions
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // action[2:0], sample_index[8:3], input_index[12:9],
                                    // output_index[15:13], value[31:16]
   input  logic        req_tlast,   // last_element
   // response transactions
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // column[2:0], result[50:3], zero fill[55:51]
   output logic [1:0]  rsp_tuser,   // kind[1:0]
   output logic        rsp_tlast    // last result of the transaction
);

   localparam int ROW_W = (IN_DIM > 1) ? $clog2(IN_DIM) : 1;
   localparam int NP    = (OUT_DIM < 8) ? OUT_DIM : 8;
   localparam int NP_W  = (NP > 1) ? $clog2(NP) : 1;

   cmd_type          cmd;
   sts_type          sts;
   logic [ROW_W-1:0] row_idx;
   logic [NP_W-1:0]  lane_idx;

   // sequencing of each transaction
   lla_control #(
      .IN_DIM  (IN_DIM),
      .OUT_DIM (OUT_DIM)
   ) u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd),
      .row_idx    (row_idx),
      .lane_idx   (lane_idx)
   );

   // storage, MAC lanes and response register
   lla_datapath #(
      .IN_DIM  (IN_DIM),
      .OUT_DIM (OUT_DIM),
      .BATCH   (BATCH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .row_idx    (row_idx),
      .lane_idx   (lane_idx),
      .sts        (sts)
   );

endmodule

FILE: hdl/lla_datapath.sv
// Datapath: memories, MAC lanes, gradient update, regularized read and output register.
module lla_datapath import lla_pkg::*; #(
   parameter int IN_DIM  = 16,
   parameter int OUT_DIM = 8,
   parameter int BATCH   = 64,
   localparam int ROW_W  = (IN_DIM > 1) ? $clog2(IN_DIM) : 1,
   localparam int LN_W   = (OUT_DIM > 1) ? $clog2(OUT_DIM) : 1,
   localparam int NP     = (OUT_DIM < 8) ? OUT_DIM : 8,
   localparam int NP_W   = (NP > 1) ? $clog2(NP) : 1,
   localparam int XA_W   = (BATCH * IN_DIM > 1) ? $clog2(BATCH * IN_DIM) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [15:0]      csr_wdata,
   input  logic [31:0]      req_tdata,
   input  logic             req_tlast,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [55:0]      rsp_tdata,
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast,
   input  cmd_type          cmd,
   input  logic [ROW_W-1:0] row_idx,
   input  logic [NP_W-1:0]  lane_idx,
   output sts_type          sts
);

   // item fields
   act_type            act_ff;
   logic [5:0]         s_ff;
   logic [3:0]         r_ff;
   logic [2:0]         c_ff;
   logic signed [15:0] v_ff;
   logic               lastel_ff;

   logic [15:0] lam_ff;

   logic [OUT_DIM-1:0][15:0] wrow [IN_DIM];
   logic [OUT_DIM-1:0][RES_W-1:0] gmem [IN_DIM];
   logic [15:0] xmem [BATCH*IN_DIM];

   logic [OUT_DIM-1:0][15:0]      w_rd_ff;
   logic [OUT_DIM-1:0][RES_W-1:0] g_rd_ff;
   logic signed [15:0]            x_rd_ff;

   logic signed [15:0]      bias_ff [OUT_DIM];
   logic signed [RES_W-1:0] bg_ff   [OUT_DIM];

   logic v1_ff, v2_ff;
   logic [ROW_W-1:0] i2_ff;
   logic signed [31:0] prod_ff [NP];
   logic signed [RES_W-1:0] gsel_ff;
   logic signed [ACC_W-1:0] acc_ff [NP];

   logic signed [32:0]      rd_prod_ff;
   logic signed [RES_W-1:0] rd_g_ff;
   logic                    rd_ok_ff;

   logic              rsp_valid_ff;
   logic [1:0]        kind_ff;
   logic [2:0]        col_ff;
   logic [RES_W-1:0]  res_ff;
   logic              last_ff;

   logic [ROW_W-1:0] r_row;
   logic [LN_W-1:0]  c_ln;
   logic [ROW_W-1:0] rd_row;
   logic [XA_W-1:0]  x_waddr, x_raddr;
   logic s_ok, r_ok, c_ok;
   logic signed [RES_W-1:0] gnew;
   logic signed [15:0]      sel_w;
   logic signed [RES_W-1:0] sel_g;
   logic signed [RES_W-1:0] rd_sum;
   logic signed [RES_W-1:0] acc_ext;

   assign r_row   = ROW_W'(r_ff);
   assign c_ln    = LN_W'(c_ff);
   assign rd_row  = cmd.mac_issue ? row_idx : r_row;
   assign x_waddr = XA_W'(32'(s_ff) * IN_DIM + 32'(r_ff));
   assign x_raddr = XA_W'(32'(s_ff) * IN_DIM + 32'(row_idx));
   assign s_ok    = 32'(s_ff) < BATCH;
   assign r_ok    = 32'(r_ff) < IN_DIM;
   assign c_ok    = 32'(c_ff) < OUT_DIM;

   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         act_ff    <= act_type'(req_tdata[2:0]);
         s_ff      <= req_tdata[8:3];
         r_ff      <= req_tdata[12:9];
         c_ff      <= req_tdata[15:13];
         v_ff      <= req_tdata[31:16];
         lastel_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lam_ff <= '0;
      end else if (csr_we) begin
         lam_ff <= csr_wdata;
      end
   end

   // weight rows, one lane per column
   always_ff @(posedge clock) begin
      if (cmd.clr_w) begin
         wrow[row_idx] <= '0;
      end else if (cmd.w_we) begin
         wrow[r_row][c_ln] <= v_ff;
      end
      w_rd_ff <= wrow[rd_row];
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_g) begin
         gmem[row_idx] <= '0;
      end else if (v2_ff && act_ff == ACT_ERROR) begin
         gmem[i2_ff][c_ln] <= gnew;
      end
      g_rd_ff <= gmem[rd_row];
   end

   always_ff @(posedge clock) begin
      if (cmd.x_we) begin
         xmem[x_waddr] <= v_ff;
      end
      x_rd_ff <= xmem[x_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < OUT_DIM; k++) begin
            bias_ff[k] <= '0;
            bg_ff[k]   <= '0;
         end
      end else begin
         if (cmd.b_we) begin
            bias_ff[c_ln] <= v_ff;
         end
         if (cmd.bg_clr) begin
            for (int k = 0; k < OUT_DIM; k++) begin
               bg_ff[k] <= '0;
            end
         end else if (cmd.bg_sub) begin
            bg_ff[c_ln] <= sat48({bg_ff[c_ln][RES_W-1], bg_ff[c_ln]}
                                 - {{21{v_ff[15]}}, v_ff, 12'b0});
         end
      end
   end

   // MAC pipeline: read, multiply, accumulate or write back
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.mac_issue;
         v2_ff <= v1_ff;
      end
   end

   logic [ROW_W-1:0] i1_ff;
   always_ff @(posedge clock) begin
      i1_ff   <= row_idx;
      i2_ff   <= i1_ff;
      gsel_ff <= g_rd_ff[c_ln];
      for (int k = 0; k < NP; k++) begin
         if (k == 0 && act_ff == ACT_ERROR) begin
            prod_ff[k] <= x_rd_ff * v_ff;
         end else begin
            prod_ff[k] <= x_rd_ff * $signed(w_rd_ff[k]);
         end
      end
   end

   assign gnew = sat48({gsel_ff[RES_W-1], gsel_ff} - {{17{prod_ff[0][31]}}, prod_ff[0]});

   always_ff @(posedge clock) begin
      for (int k = 0; k < NP; k++) begin
         if (cmd.acc_init) begin
            acc_ff[k] <= {{(ACC_W-28){bias_ff[k][15]}}, bias_ff[k], 12'b0};
         end else if (v2_ff && act_ff == ACT_STORE_X) begin
            acc_ff[k] <= acc_ff[k] + {{(ACC_W-32){prod_ff[k][31]}}, prod_ff[k]};
         end
      end
   end

   // regularized gradient read
   assign sel_w = (act_ff == ACT_READ_WG) ? $signed(w_rd_ff[c_ln]) : bias_ff[c_ln];
   assign sel_g = (act_ff == ACT_READ_WG) ? $signed(g_rd_ff[c_ln]) : bg_ff[c_ln];

   always_ff @(posedge clock) begin
      if (cmd.rd_mul) begin
         rd_prod_ff <= $signed({1'b0, lam_ff}) * sel_w;
         rd_g_ff    <= sel_g;
         rd_ok_ff   <= (act_ff == ACT_READ_WG) ? (r_ok && c_ok) : c_ok;
      end
   end

   assign rd_sum  = sat48({rd_g_ff[RES_W-1], rd_g_ff} + {{16{rd_prod_ff[32]}}, rd_prod_ff});
   assign acc_ext = {{(RES_W-ACC_W){acc_ff[lane_idx][ACC_W-1]}}, acc_ff[lane_idx]};

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_pred || cmd.out_grad) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_pred) begin
         kind_ff <= KIND_PRED;
         col_ff  <= 3'(lane_idx);
         res_ff  <= acc_ext;
         last_ff <= cmd.out_last;
      end else if (cmd.out_grad) begin
         kind_ff <= (act_ff == ACT_READ_WG) ? KIND_WGRAD : KIND_BGRAD;
         col_ff  <= c_ff;
         res_ff  <= rd_ok_ff ? rd_sum : '0;
         last_ff <= 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, res_ff, col_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

   assign sts.act       = act_ff;
   assign sts.lastel    = lastel_ff;
   assign sts.s_ok      = s_ok;
   assign sts.r_ok      = r_ok;
   assign sts.c_ok      = c_ok;
   assign sts.pipe_busy = v1_ff || v2_ff;
   assign sts.out_free  = !rsp_valid_ff || rsp_tready;

endmodule

FILE: hdl/lla_control.sv
// Controller: sequences item actions, clearing sweeps and result delivery.
module lla_control import lla_pkg::*; #(
   parameter int IN_DIM  = 16,
   parameter int OUT_DIM = 8,
   localparam int ROW_W  = (IN_DIM > 1) ? $clog2(IN_DIM) : 1,
   localparam int NP     = (OUT_DIM < 8) ? OUT_DIM : 8,
   localparam int NP_W   = (NP > 1) ? $clog2(NP) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  sts_type          sts,
   output cmd_type          cmd,
   output logic [ROW_W-1:0] row_idx,
   output logic [NP_W-1:0]  lane_idx
);

   localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(IN_DIM - 1);
   localparam logic [NP_W-1:0]  LANE_LAST = NP_W'(NP - 1);

   state_type        state_ff, state_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [NP_W-1:0]  lane_ff, lane_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         row_ff   <= '0;
         lane_ff  <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         lane_ff  <= lane_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      row_in     = row_ff;
      lane_in    = lane_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_w = 1'b1;
            cmd.clr_g = 1'b1;
            row_in    = row_ff + 1'b1;
            if (row_ff == ROW_LAST) begin
               row_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.cap  = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_IDLE;
            row_in   = '0;
            lane_in  = '0;
            unique case (sts.act)
               ACT_LOAD_W:  cmd.w_we = sts.r_ok && sts.c_ok;
               ACT_LOAD_B:  cmd.b_we = sts.c_ok;
               ACT_STORE_X: begin
                  if (sts.s_ok) begin
                     cmd.x_we = sts.r_ok;
                     if (sts.lastel) begin
                        cmd.acc_init = 1'b1;
                        state_in     = ST_MAC;
                     end
                  end
               end
               ACT_CLEAR_G: begin
                  cmd.bg_clr = 1'b1;
                  state_in   = ST_GCLR;
               end
               ACT_ERROR: begin
                  if (sts.s_ok && sts.c_ok) begin
                     cmd.bg_sub = 1'b1;
                     state_in   = ST_MAC;
                  end
               end
               ACT_READ_WG, ACT_READ_BG: state_in = ST_RD_A;
               ACT_NONE: state_in = ST_IDLE;
               default:  state_in = ST_IDLE;
            endcase
         end
         ST_MAC: begin
            cmd.mac_issue = 1'b1;
            row_in        = row_ff + 1'b1;
            if (row_ff == ROW_LAST) begin
               row_in   = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!sts.pipe_busy) begin
               state_in = (sts.act == ACT_STORE_X) ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.out_pred = 1'b1;
               cmd.out_last = (lane_ff == LANE_LAST);
               lane_in      = lane_ff + 1'b1;
               if (lane_ff == LANE_LAST) begin
                  lane_in  = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_RD_A: state_in = ST_RD_B;
         ST_RD_B: begin
            cmd.rd_mul = 1'b1;
            state_in   = ST_RD_C;
         end
         ST_RD_C: begin
            if (sts.out_free) begin
               cmd.out_grad = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_GCLR: begin
            cmd.clr_g = 1'b1;
            row_in    = row_ff + 1'b1;
            if (row_ff == ROW_LAST) begin
               row_in   = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign row_idx  = row_ff;
   assign lane_idx = lane_ff;

endmodule
